// File: hdl/swsfd_pkg.sv
// ============================================================================
// swsfd_pkg - shared definitions for the single-wire sensor frame decoder
// Event classes, phase and status codes, and configuration register layout.
// ============================================================================
package swsfd_pkg;

    // Configuration port layout.
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_IGNORE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_WIN_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_WIN_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_BELOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WIN_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WIN_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT_ABOVE  = 3'd7;

    // Register reset values, in index order.
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        16'd6000, 16'd25, 16'd125, 16'd190, 16'd10, 16'd60, 16'd155, 16'd90
    };

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Event classes produced by the front.
    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // Frame phases.
    localparam logic [1:0] PH_STOPPED  = 2'd0;
    localparam logic [1:0] PH_RESPONSE = 2'd1;
    localparam logic [1:0] PH_DATA     = 2'd2;
    localparam logic [1:0] PH_ACQUIRED = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_NOT_STARTED = 3'd0;
    localparam logic [2:0] ST_OK          = 3'd1;
    localparam logic [2:0] ST_TIMEOUT     = 3'd2;
    localparam logic [2:0] ST_RESPONSE    = 3'd3;
    localparam logic [2:0] ST_GLITCH      = 3'd4;
    localparam logic [2:0] ST_DATA        = 3'd5;
    localparam logic [2:0] ST_CHECKSUM    = 3'd6;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] time_us;
    } q_head_t;

endpackage

// File: hdl/swsfd_in_if.sv
// ============================================================================
// swsfd_in_if - event channel
// Carries one timestamped event item with a valid/ready handshake.
// ============================================================================
interface swsfd_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] time_us;

    modport source (output valid, output req_type, output time_us, input ready);
    modport sink   (input valid, input req_type, input time_us, output ready);
endinterface

// File: hdl/swsfd_out_if.sv
// ============================================================================
// swsfd_out_if - result channel
// Carries one decoder result item with a valid/ready handshake.
// ============================================================================
interface swsfd_out_if;
    logic       valid;
    logic       ready;
    logic       start_accepted;
    logic       busy_res;
    logic [2:0] status_code;
    logic [7:0] humidity;
    logic [7:0] temperature;

    modport source (output valid, output start_accepted, output busy_res,
                    output status_code, output humidity, output temperature,
                    input ready);
    modport sink   (input valid, input start_accepted, input busy_res,
                    input status_code, input humidity, input temperature,
                    output ready);
endinterface

// File: hdl/swsfd_front.sv
// ============================================================================
// swsfd_front - event intake and queue
// Accepts event items, classifies them and holds them in a small FIFO.
// ============================================================================
module swsfd_front #(
    parameter int QUEUE_DEPTH = swsfd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    swsfd_in_if.sink            events,
    output swsfd_pkg::q_head_t  head,
    input  logic                pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              op_mem   [QUEUE_DEPTH];
    logic [31:0]       time_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              do_pop;
    logic              op_class;

    assign events.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push         = events.valid && events.ready;
    assign do_pop       = pop && (count_reg != '0);
    assign op_class     = events.req_type ? swsfd_pkg::OP_EDGE : swsfd_pkg::OP_START;

    assign head.valid   = (count_reg != '0);
    assign head.op      = op_mem[rd_ptr_reg];
    assign head.time_us = time_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= op_class;
            time_mem[wr_ptr_reg] <= events.time_us;
        end
    end

endmodule

// File: hdl/swsfd_back.sv
// ============================================================================
// swsfd_back - frame decoding engine
// Applies the timing rules to queued events and registers one result per event.
// ============================================================================
module swsfd_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swsfd_pkg::CFG_W-1:0]           cfg_data,
    input  swsfd_pkg::q_head_t                    head,
    output logic                                  pop,
    swsfd_out_if.source                           results
);

    logic [swsfd_pkg::CFG_W-1:0] cfg_reg [swsfd_pkg::NUM_CFG];

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  frame_reg [5];
    logic [7:0]  frame_next [5];
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] last_reg, last_next;
    logic [7:0]  hum_reg, hum_next;
    logic [7:0]  temp_reg, temp_next;
    logic [2:0]  status_reg, status_next;
    logic        accepted;

    logic [31:0] diff;
    logic [2:0]  bi;
    logic [7:0]  chk_sum;

    logic        out_valid_reg;
    logic        out_acc_reg;
    logic        out_busy_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_hum_reg;
    logic [7:0]  out_temp_reg;

    // The interval is a signed 32-bit value; thresholds are nonnegative.
    function automatic logic iv_gt(input logic [31:0] d, input logic [15:0] r);
        return !d[31] && (d[30:0] > {15'd0, r});
    endfunction

    function automatic logic iv_lt(input logic [31:0] d, input logic [15:0] r);
        return d[31] || (d[30:0] < {15'd0, r});
    endfunction

    assign pop  = head.valid && (!out_valid_reg || results.ready);
    assign diff = head.time_us - last_reg;
    assign bi   = (byte_idx_reg >= 3'd5) ? byte_idx_reg - 3'd5 : byte_idx_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        frame_next    = frame_reg;
        bit_pos_next  = bit_pos_reg;
        byte_idx_next = byte_idx_reg;
        last_next     = last_reg;
        hum_next      = hum_reg;
        temp_next     = temp_reg;
        status_next   = status_reg;
        accepted      = 1'b0;
        chk_sum       = 8'd0;
        if (pop)
        begin
            if (head.op == swsfd_pkg::OP_START)
            begin
                if (phase_reg == swsfd_pkg::PH_STOPPED || phase_reg == swsfd_pkg::PH_ACQUIRED)
                begin
                    accepted      = 1'b1;
                    phase_next    = swsfd_pkg::PH_RESPONSE;
                    frame_next    = '{default: 8'd0};
                    bit_pos_next  = 3'd7;
                    byte_idx_next = 3'd0;
                    hum_next      = 8'd0;
                    temp_next     = 8'd0;
                    last_next     = head.time_us;
                end
            end
            else
            begin
                unique case (phase_reg)
                    swsfd_pkg::PH_RESPONSE:
                    begin
                        last_next = head.time_us;
                        if (iv_gt(diff, cfg_reg[swsfd_pkg::CFG_TIMEOUT_LIMIT]))
                        begin
                            status_next = swsfd_pkg::ST_TIMEOUT;
                            phase_next  = swsfd_pkg::PH_STOPPED;
                        end
                        else if (iv_lt(diff, cfg_reg[swsfd_pkg::CFG_RESP_IGNORE]))
                        begin
                            last_next = last_reg;
                        end
                        else if (iv_gt(diff, cfg_reg[swsfd_pkg::CFG_RESP_WIN_LOW]) &&
                                 iv_lt(diff, cfg_reg[swsfd_pkg::CFG_RESP_WIN_HIGH]))
                        begin
                            phase_next = swsfd_pkg::PH_DATA;
                        end
                        else
                        begin
                            status_next = swsfd_pkg::ST_RESPONSE;
                            phase_next  = swsfd_pkg::PH_STOPPED;
                        end
                    end
                    swsfd_pkg::PH_DATA:
                    begin
                        last_next = head.time_us;
                        if (iv_gt(diff, cfg_reg[swsfd_pkg::CFG_TIMEOUT_LIMIT]))
                        begin
                            status_next = swsfd_pkg::ST_TIMEOUT;
                            phase_next  = swsfd_pkg::PH_STOPPED;
                        end
                        else if (iv_lt(diff, cfg_reg[swsfd_pkg::CFG_GLITCH_BELOW]))
                        begin
                            status_next = swsfd_pkg::ST_GLITCH;
                            phase_next  = swsfd_pkg::PH_STOPPED;
                        end
                        else if (iv_gt(diff, cfg_reg[swsfd_pkg::CFG_DATA_WIN_LOW]) &&
                                 iv_lt(diff, cfg_reg[swsfd_pkg::CFG_DATA_WIN_HIGH]))
                        begin
                            if (iv_gt(diff, cfg_reg[swsfd_pkg::CFG_ONE_BIT_ABOVE]))
                            begin
                                frame_next[bi][bit_pos_reg] = 1'b1;
                            end
                            if (bit_pos_reg == 3'd0)
                            begin
                                bit_pos_next = 3'd7;
                                if (byte_idx_reg >= 3'd4)
                                begin
                                    // Last bit of the frame: publish and verify.
                                    byte_idx_next = 3'd5;
                                    hum_next      = frame_next[0];
                                    temp_next     = frame_next[2];
                                    chk_sum       = frame_next[0] + frame_next[2];
                                    if (frame_next[4] != chk_sum)
                                    begin
                                        status_next = swsfd_pkg::ST_CHECKSUM;
                                        phase_next  = swsfd_pkg::PH_STOPPED;
                                    end
                                    else
                                    begin
                                        status_next = swsfd_pkg::ST_OK;
                                        phase_next  = swsfd_pkg::PH_ACQUIRED;
                                    end
                                end
                                else
                                begin
                                    byte_idx_next = byte_idx_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg - 3'd1;
                            end
                        end
                        else
                        begin
                            status_next = swsfd_pkg::ST_DATA;
                            phase_next  = swsfd_pkg::PH_STOPPED;
                        end
                    end
                    default:
                    begin
                        // Edges outside a frame are dropped.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swsfd_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= swsfd_pkg::CFG_RESET[i];
            end
            phase_reg    <= swsfd_pkg::PH_STOPPED;
            for (int i = 0; i < 5; i++)
            begin
                frame_reg[i] <= 8'd0;
            end
            bit_pos_reg   <= 3'd7;
            byte_idx_reg  <= 3'd0;
            last_reg      <= 32'd0;
            hum_reg       <= 8'd0;
            temp_reg      <= 8'd0;
            status_reg    <= swsfd_pkg::ST_NOT_STARTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            phase_reg    <= phase_next;
            frame_reg    <= frame_next;
            bit_pos_reg  <= bit_pos_next;
            byte_idx_reg <= byte_idx_next;
            last_reg     <= last_next;
            hum_reg      <= hum_next;
            temp_reg     <= temp_next;
            status_reg   <= status_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_acc_reg    <= accepted;
            out_busy_reg   <= (phase_next == swsfd_pkg::PH_RESPONSE) ||
                              (phase_next == swsfd_pkg::PH_DATA);
            out_status_reg <= status_next;
            out_hum_reg    <= hum_next;
            out_temp_reg   <= temp_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.start_accepted = out_acc_reg;
    assign results.busy_res       = out_busy_reg;
    assign results.status_code    = out_status_reg;
    assign results.humidity       = out_hum_reg;
    assign results.temperature    = out_temp_reg;

endmodule

// File: hdl/single_wire_sensor_frame_decoder.sv
// ============================================================================
// single_wire_sensor_frame_decoder - single-wire sensor frame decoder top level
// Turns start requests and timestamped line edges into frame status results.
// ============================================================================
//
//  Channel   Direction  Handshake      Payload
//  events    in         valid/ready    req_type, time_us
//  results   out        valid/ready    start_accepted, busy_res, status_code,
//                                      humidity, temperature
//  cfg       in         cfg_we only    cfg_index, cfg_data
//
// One item is accepted per cycle while the front queue has room, and each item
// yields exactly one result item. An item is written into the front queue and
// waits at its head until the engine's output register is free or being taken;
// the engine then pops it, evaluates it in a single subtract-and-compare step
// and its output register captures the result. The queue holds QUEUE_DEPTH
// items, so events keeps accepting while a result waits; it deasserts ready
// only when the queue is full behind a stalled results channel. Reset is
// asynchronous and active low; it returns the queue pointers, the frame state,
// the timing registers and the result valid flag to their reset values at once.
//
// The front classifies each item as a start request or a line edge and queues
// it. The back owns the frame state: it measures the signed interval since the
// last reference edge, walks the response and data timing rules, shifts data
// bits in most significant bit first, and checks the checksum at the end of
// the fortieth bit. Configuration registers live in the back and may be
// written whenever the block is idle.
//
module single_wire_sensor_frame_decoder #(
    parameter int QUEUE_DEPTH = swsfd_pkg::QUEUE_DEPTH  // supported range 2 to 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    swsfd_in_if.sink                          events,
    swsfd_out_if.source                       results,
    input  logic                              cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swsfd_pkg::CFG_W-1:0]       cfg_data
);

    // Head of the queue and the pop strobe from the back.
    swsfd_pkg::q_head_t head;
    logic               pop;

    swsfd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (events),
        .head   (head),
        .pop    (pop)
    );

    swsfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .results   (results)
    );

`ifndef SYNTHESIS
    // An item taken from the queue must show up as a result in the next cycle.
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> results.valid)
        else $error("queued item did not produce a result");

    // The engine pops only what the queue actually holds.
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop with empty queue");

    // An accepted start always leaves the decoder busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.start_accepted) |-> results.busy_res)
        else $error("accepted start without busy");

    // While a frame is in progress the published bytes stay cleared.
    a_busy_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.busy_res) |->
            (results.humidity == 8'd0 && results.temperature == 8'd0))
        else $error("frame bytes published during a frame");
`endif

endmodule

// File: tb/tb_single_wire_sensor_frame_decoder.sv
// ============================================================================
// tb_single_wire_sensor_frame_decoder - self-checking testbench
// Drives start requests and timestamped line edges into the frame decoder,
// predicts every result item with an in-bench model of the frame timing rules,
// and compares each accepted result item field by field, under random idling
// on both channels and several timing register settings.
// ============================================================================
module tb_single_wire_sensor_frame_decoder;

    import swsfd_pkg::*;

    // The watchdog stops the run by force once the cycle counter reaches this limit.
    localparam int CYCLE_LIMIT = 400000;

    // One result item as the decoder reports it.
    typedef struct packed {
        logic       start_accepted;
        logic       busy_res;
        logic [2:0] status_code;
        logic [7:0] humidity;
        logic [7:0] temperature;
    } frame_result_t;

    // A full set of timing registers, in register index order.
    typedef logic [CFG_W-1:0] timing_set_t [NUM_CFG];

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    swsfd_in_if  ev_if ();
    swsfd_out_if res_if ();

    single_wire_sensor_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Frame model state. It mirrors what the decoder must hold: the timing
    // registers, the frame phase, the five frame bytes with the bit cursor,
    // the reference edge time and the reported values.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] timing_reg [NUM_CFG];
    logic [1:0]       fr_phase;
    logic [7:0]       fr_bytes [5];
    logic [2:0]       fr_bit;
    logic [2:0]       fr_byte;
    logic [31:0]      ref_time;
    logic [7:0]       fr_hum;
    logic [7:0]       fr_temp;
    logic [2:0]       fr_status;

    // Results that the model has computed and the decoder has not yet delivered.
    frame_result_t pending_results [$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          items_sent  = 0;
    int          rx_wait     = 0;
    bit          idling_on   = 1'b1;
    logic [31:0] t_now       = '0;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the decoder.
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        for (int i = 0; i < NUM_CFG; i++) begin
            timing_reg[i] = CFG_RESET[i];
        end
        for (int i = 0; i < 5; i++) begin
            fr_bytes[i] = 8'h00;
        end
        fr_phase  = PH_STOPPED;
        fr_bit    = 3'd7;
        fr_byte   = 3'd0;
        ref_time  = 32'h0;
        fr_hum    = 8'h00;
        fr_temp   = 8'h00;
        fr_status = ST_NOT_STARTED;
    endfunction

    function automatic void stop_frame(input logic [2:0] code);
        fr_status = code;
        fr_phase  = PH_STOPPED;
    endfunction

    // Applies one accepted item to the model and returns the result item that
    // the decoder must produce for it.
    function automatic frame_result_t decode_event(input logic op, input logic [31:0] t);
        frame_result_t r;
        logic [31:0]   prev;
        logic [7:0]    sum;
        int            d;
        int            bi;
        int            to_lim;
        int            ign;
        int            rwl;
        int            rwh;
        int            gl;
        int            dwl;
        int            dwh;
        int            oba;

        // Registers are compared as nonnegative numbers against the signed
        // interval, so they are widened into ints first.
        to_lim = timing_reg[CFG_TIMEOUT_LIMIT];
        ign    = timing_reg[CFG_RESP_IGNORE];
        rwl    = timing_reg[CFG_RESP_WIN_LOW];
        rwh    = timing_reg[CFG_RESP_WIN_HIGH];
        gl     = timing_reg[CFG_GLITCH_BELOW];
        dwl    = timing_reg[CFG_DATA_WIN_LOW];
        dwh    = timing_reg[CFG_DATA_WIN_HIGH];
        oba    = timing_reg[CFG_ONE_BIT_ABOVE];

        r.start_accepted = 1'b0;
        if (op == OP_START) begin
            // A start is only taken when no frame is in progress. The status
            // of the previous frame stays visible until this one resolves.
            if (fr_phase == PH_STOPPED || fr_phase == PH_ACQUIRED) begin
                r.start_accepted = 1'b1;
                fr_phase = PH_RESPONSE;
                for (int i = 0; i < 5; i++) begin
                    fr_bytes[i] = 8'h00;
                end
                fr_bit   = 3'd7;
                fr_byte  = 3'd0;
                fr_hum   = 8'h00;
                fr_temp  = 8'h00;
                ref_time = t;
            end
        end else if (fr_phase == PH_RESPONSE || fr_phase == PH_DATA) begin
            // The interval wraps with the timestamp and is read as signed.
            d        = $signed(t - ref_time);
            prev     = ref_time;
            ref_time = t;
            if (d > to_lim) begin
                stop_frame(ST_TIMEOUT);
            end else if (fr_phase == PH_RESPONSE) begin
                // Short or negative response intervals leave no trace at all.
                if (d < ign) begin
                    ref_time = prev;
                end else if (d > rwl && d < rwh) begin
                    fr_phase = PH_DATA;
                end else begin
                    stop_frame(ST_RESPONSE);
                end
            end else if (d < gl) begin
                stop_frame(ST_GLITCH);
            end else if (d > dwl && d < dwh) begin
                bi = fr_byte % 5;
                if (d > oba) begin
                    fr_bytes[bi][fr_bit] = 1'b1;
                end
                if (fr_bit == 3'd0) begin
                    fr_bit = 3'd7;
                    if (fr_byte >= 3'd4) begin
                        // Fortieth bit: publish the bytes, then check the sum.
                        fr_byte = 3'd5;
                        fr_hum  = fr_bytes[0];
                        fr_temp = fr_bytes[2];
                        sum     = fr_bytes[0] + fr_bytes[2];
                        if (fr_bytes[4] != sum) begin
                            stop_frame(ST_CHECKSUM);
                        end else begin
                            fr_status = ST_OK;
                            fr_phase  = PH_ACQUIRED;
                        end
                    end else begin
                        fr_byte = fr_byte + 3'd1;
                    end
                end else begin
                    fr_bit = fr_bit - 3'd1;
                end
            end else begin
                stop_frame(ST_DATA);
            end
        end
        // Edges that arrive while stopped or acquired change nothing.

        r.busy_res    = (fr_phase == PH_RESPONSE || fr_phase == PH_DATA);
        r.status_code = fr_status;
        r.humidity    = fr_hum;
        r.temperature = fr_temp;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, where the decoder's outputs
    // still hold their values from before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && ev_if.valid && ev_if.ready) begin
            pending_results.push_back(decode_event(ev_if.req_type, ev_if.time_us));
        end
    end

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    always @(posedge clk) begin
        frame_result_t exp_r;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no item outstanding");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("start_accepted", exp_r.start_accepted, res_if.start_accepted);
                check_field("busy_res", exp_r.busy_res, res_if.busy_res);
                check_field("status_code", exp_r.status_code, res_if.status_code);
                check_field("humidity", exp_r.humidity, res_if.humidity);
                check_field("temperature", exp_r.temperature, res_if.temperature);
            end
            // Each accepted result draws the stall before the next one.
            rx_wait = idling_on ? $urandom_range(9, 0) : 0;
        end
    end

    // The result side holds ready low while the drawn stall counts down, then
    // raises it until the next result item is taken.
    initial begin
        forever begin
            @(negedge clk);
            if (rx_wait > 0) begin
                res_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers.
    // ------------------------------------------------------------------------

    // Sends one item. Valid stays high straight into the next item when no
    // gap is drawn, so it is never lowered and raised in one time step.
    task automatic send_event(input logic op, input logic [31:0] t);
        int gap;
        gap = idling_on ? $urandom_range(9, 0) : 0;
        @(negedge clk);
        if (gap != 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_if.valid    <= 1'b1;
        ev_if.req_type <= op;
        ev_if.time_us  <= t;
        do @(posedge clk); while (!ev_if.ready);
        items_sent++;
    endtask

    // Holds the event side idle until every outstanding result item has been
    // checked, then lets the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        ev_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        timing_reg[idx] = val;
    endtask

    // Writes every timing register, always from an idle decoder.
    task automatic load_timing(input timing_set_t v);
        drain_results();
        for (int i = 0; i < NUM_CFG; i++) begin
            write_cfg(i[CFG_IDX_W-1:0], v[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Interval generation for frames.
    // ------------------------------------------------------------------------
    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // An interval in [lo, hi]; when the range is empty under the current
    // registers, any short interval will do and the model sorts it out.
    function automatic logic [31:0] pick_us(input int lo, input int hi);
        if (lo < 0) begin
            lo = 0;
        end
        if (lo <= hi) begin
            return $urandom_range(hi, lo);
        end
        return $urandom_range(200, 0);
    endfunction

    // An interval meant to break the frame: below or above the window, past
    // the timeout, or (for data bits) negative, which reads as a glitch.
    function automatic logic [31:0] bad_interval(input int lo, input int hi, input int to_lim,
                                                 input bit neg_ok);
        int kind;
        kind = $urandom_range(neg_ok ? 3 : 2, 0);
        case (kind)
            0:       return pick_us(0, lo);
            1:       return pick_us(hi, hi + 100);
            2:       return to_lim + 1 + $urandom_range(500, 0);
            default: return -$urandom_range(1000, 1);
        endcase
    endfunction

    // Sends one frame: an optional clearing edge, a start, optional refused
    // starts and ignored short edges, the response edge and forty data bits
    // built from random bytes. Most checksums are right; some frames are cut
    // short by one bad interval.
    task automatic send_frame();
        int          to_lim;
        int          ign;
        int          rwl;
        int          rwh;
        int          gl;
        int          dwl;
        int          dwh;
        int          oba;
        int          bad_pos;
        logic [31:0] gap;
        logic [7:0]  payload [5];

        to_lim = timing_reg[CFG_TIMEOUT_LIMIT];
        ign    = timing_reg[CFG_RESP_IGNORE];
        rwl    = timing_reg[CFG_RESP_WIN_LOW];
        rwh    = timing_reg[CFG_RESP_WIN_HIGH];
        gl     = timing_reg[CFG_GLITCH_BELOW];
        dwl    = timing_reg[CFG_DATA_WIN_LOW];
        dwh    = timing_reg[CFG_DATA_WIN_HIGH];
        oba    = timing_reg[CFG_ONE_BIT_ABOVE];

        // Some frames run with no idling on either side at all.
        idling_on = ($urandom_range(3, 0) != 0);

        // A far edge times out whatever frame an earlier abort left open, so
        // that the start below is taken. Now and then it is left out, and the
        // start may then be refused.
        if ($urandom_range(4, 0) != 0) begin
            send_event(OP_EDGE, t_now + 32'd100000);
        end

        case ($urandom_range(7, 0))
            0:       t_now = $urandom;
            1:       t_now = 32'hFFFF_FF00 + $urandom_range(255, 0);
            default: t_now = t_now + $urandom_range(2000, 0);
        endcase
        send_event(OP_START, t_now);
        if ($urandom_range(4, 0) == 0) begin
            send_event(OP_START, t_now + $urandom_range(100, 0));
        end
        if ($urandom_range(3, 0) == 0) begin
            if ($urandom_range(1, 0) != 0) begin
                send_event(OP_EDGE, t_now + pick_us(0, ign - 1));
            end else begin
                send_event(OP_EDGE, t_now - $urandom_range(1000, 1));
            end
        end

        for (int i = 0; i < 4; i++) begin
            payload[i] = $urandom;
        end
        payload[4] = ($urandom_range(5, 0) == 0) ? 8'($urandom) : payload[0] + payload[2];
        bad_pos = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 0) : -1;

        if (bad_pos == 0) begin
            gap = bad_interval(rwl, rwh, to_lim, 1'b0);
        end else begin
            gap = pick_us(imax(rwl + 1, ign), imin(rwh - 1, to_lim));
        end
        t_now = t_now + gap;
        send_event(OP_EDGE, t_now);
        if (bad_pos == 0) begin
            return;
        end

        for (int b = 0; b < 40; b++) begin
            if (bad_pos == b + 1) begin
                gap = bad_interval(dwl, dwh, to_lim, 1'b1);
            end else if (payload[b / 8][7 - (b % 8)]) begin
                gap = pick_us(imax(imax(dwl, oba) + 1, gl), imin(dwh - 1, to_lim));
            end else begin
                gap = pick_us(imax(dwl + 1, gl), imin(imin(oba, dwh - 1), to_lim));
            end
            t_now = t_now + gap;
            send_event(OP_EDGE, t_now);
            if (bad_pos == b + 1) begin
                return;
            end
        end

        // A late edge after the frame lands in acquired or stopped.
        if ($urandom_range(2, 0) == 0) begin
            send_event(OP_EDGE, t_now + $urandom_range(200, 0));
        end
    endtask

    // Mostly well-formed frames, with bursts of unrelated items and now and
    // then a full pause until every result item has been checked.
    task automatic run_random(input int n);
        int target;
        int pick;
        int burst;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 75) begin
                send_frame();
            end else if (pick < 93) begin
                burst = $urandom_range(6, 1);
                repeat (burst) begin
                    if ($urandom_range(1, 0) != 0) begin
                        t_now = $urandom;
                    end else begin
                        t_now = t_now + $urandom_range(300, 0);
                    end
                    send_event($urandom_range(1, 0) ? OP_EDGE : OP_START, t_now);
                end
            end else begin
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Short hand-written sequences at the reset timing: every timing rule and every
    // window boundary, with the reference time wrapping past zero.
    task automatic test_directed_cases();
        logic [31:0] t;
        idling_on = 1'b1;
        send_event(OP_EDGE, 32'h0000_0000);          // edge while idle is ignored
        t = 32'hFFFF_FFF0;
        send_event(OP_START, t);
        send_event(OP_START, t + 32'd3);             // refused, a frame is open
        send_event(OP_EDGE, t + 32'd10);             // short response edge
        send_event(OP_EDGE, t - 32'd5);              // negative interval is short too
        t = t + 32'd150;                             // wraps past zero
        send_event(OP_EDGE, t);                      // valid response
        send_event(OP_EDGE, t + 32'd5);              // glitch
        send_event(OP_EDGE, t + 32'd100);            // ignored while stopped
        send_event(OP_START, 32'hFFFF_FFFF);
        send_event(OP_EDGE, 32'h0000_0063);          // response too short
        send_event(OP_START, 32'd5000);
        send_event(OP_EDGE, 32'd5190);               // upper response bound is exclusive
        send_event(OP_START, 32'd6000);
        send_event(OP_EDGE, 32'd6125);               // lower response bound is exclusive
        send_event(OP_START, 32'd20000);
        send_event(OP_EDGE, 32'd26000);              // at the timeout, not past it
        send_event(OP_START, 32'd30000);
        send_event(OP_EDGE, 32'd30126);
        send_event(OP_EDGE, 32'd30186);              // lower data bound is exclusive
        t = 32'd40000;
        send_event(OP_START, t);
        t = t + 32'd189; send_event(OP_EDGE, t);
        t = t + 32'd91;  send_event(OP_EDGE, t);     // one
        t = t + 32'd90;  send_event(OP_EDGE, t);     // zero at the threshold
        t = t + 32'd154; send_event(OP_EDGE, t);     // one near the top
        t = t + 32'd155; send_event(OP_EDGE, t);     // upper data bound is exclusive
        send_event(OP_START, 32'h8000_0000);
        send_event(OP_EDGE, 32'h8000_0082);
        send_event(OP_EDGE, 32'h8000_0082 + 32'd6001);  // timeout during data
        send_event(OP_START, 32'h7FFF_0000);
        send_event(OP_EDGE, 32'h7FFF_0082);
        send_event(OP_EDGE, 32'h7FFF_008C);          // at the glitch bound: data error
        t_now = 32'h7FFF_1000;
    endtask

    task automatic test_default_timing();
        run_random(500);
    endtask

    task automatic test_all_zero_timing();
        timing_set_t v;
        for (int i = 0; i < NUM_CFG; i++) begin
            v[i] = '0;
        end
        load_timing(v);
        run_random(100);
    endtask

    task automatic test_all_max_timing();
        timing_set_t v;
        for (int i = 0; i < NUM_CFG; i++) begin
            v[i] = '1;
        end
        load_timing(v);
        run_random(100);
    endtask

    // Timing sets in which the windows are ordered sensibly, so that frames still decode.
    task automatic test_random_timing();
        timing_set_t v;
        repeat (3) begin
            v[CFG_RESP_IGNORE]   = $urandom_range(60, 0);
            v[CFG_RESP_WIN_LOW]  = v[CFG_RESP_IGNORE] + $urandom_range(100, 0);
            v[CFG_RESP_WIN_HIGH] = v[CFG_RESP_WIN_LOW] + $urandom_range(150, 2);
            v[CFG_GLITCH_BELOW]  = $urandom_range(30, 0);
            v[CFG_DATA_WIN_LOW]  = v[CFG_GLITCH_BELOW] + $urandom_range(60, 0);
            v[CFG_DATA_WIN_HIGH] = v[CFG_DATA_WIN_LOW] + $urandom_range(200, 3);
            v[CFG_ONE_BIT_ABOVE] = $urandom_range(v[CFG_DATA_WIN_HIGH] - 1,
                                                  v[CFG_DATA_WIN_LOW]);
            v[CFG_TIMEOUT_LIMIT] = imax(v[CFG_RESP_WIN_HIGH], v[CFG_DATA_WIN_HIGH])
                                   + $urandom_range(3000, 0);
            load_timing(v);
            run_random(200);
        end
    endtask

    // Fully random registers, mostly unusable for frames.
    task automatic test_random_registers();
        timing_set_t v;
        for (int i = 0; i < NUM_CFG; i++) begin
            v[i] = $urandom;
        end
        load_timing(v);
        run_random(100);
    endtask

    task automatic test_restore_defaults();
        load_timing(CFG_RESET);
        run_random(100);
    endtask

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    initial begin
        ev_if.valid    <= 1'b0;
        ev_if.req_type <= OP_START;
        ev_if.time_us  <= 32'h0;
        res_if.ready   <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_TIMEOUT_LIMIT;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        reset_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_default_timing();
        test_all_zero_timing();
        test_all_max_timing();
        test_random_timing();
        test_random_registers();
        test_restore_defaults();

        // Every result item must have come; then a short quiet period shows
        // that no stray result item follows.
        drain_results();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
